// ===== src/icq_pkg.sv =====
`default_nettype none
package icq_pkg;

   // region and chunk geometry
   localparam int REGION_LENGTH = 8;
   localparam int REGION_WIDTH  = 8;
   localparam int REGION_HEIGHT = 4;
   localparam int CHUNK_LENGTH  = 16;
   localparam int CHUNK_WIDTH   = 16;
   localparam int CHUNK_HEIGHT  = 8;

   localparam int CHUNK_AREA  = REGION_LENGTH * REGION_WIDTH;
   localparam int CELL_AREA   = CHUNK_LENGTH * CHUNK_WIDTH;
   localparam int WORLD_LEN   = REGION_LENGTH * CHUNK_LENGTH;
   localparam int WORLD_WID   = REGION_WIDTH * CHUNK_WIDTH;
   localparam int WORLD_HGT   = REGION_HEIGHT * CHUNK_HEIGHT;

   // payload widths
   localparam int CHUNK_NUM_W = 8;
   localparam int CELL_NUM_W  = 11;
   localparam int WORD_W      = 32;
   localparam int SCREEN_W    = 13;
   localparam int DEPTH_W     = 13;
   localparam int TEX_U_W     = 6;
   localparam int TEX_V_W     = 10;
   localparam int VNUM_W      = 13;
   localparam int COUNT_W     = 14;
   localparam int GEO_W       = 16;

   // register port
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 5;
   localparam int REG_IDX_W = ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_VIEW    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_EMPTY   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MASK_N  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MASK_W  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MASK_S  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MASK_E  = 3'd5;

   // view directions
   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_WEST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_EAST  = 2'd3;

   // projection and texture constants
   localparam int HALF_TILE_X  = 27;
   localparam int ISO_STEP_Y   = 18;
   localparam int LEVEL_STEP_Y = 30;
   localparam int QUAD_H       = 68;
   localparam int DEPTH_SCALE  = 10;
   localparam int TEX_U_RIGHT  = 54;
   localparam int TEX_V_FLOOR_TOP = 376;
   localparam int TEX_V_MID       = 444;
   localparam int TEX_V_WALL_BOT  = 512;

   localparam logic [1:0] LAST_CORNER = 2'd3;

   typedef logic signed [GEO_W-1:0] geo_type;

   typedef struct packed {
      logic [CHUNK_NUM_W-1:0] chunk_number;
      logic [CELL_NUM_W-1:0]  cell_number;
      logic                   layer_kind;
      logic                   visible;
      logic [COUNT_W-1:0]     base_count;
   } cell_type;

endpackage
`default_nettype wire

// ===== src/icq_req_if.sv =====
`default_nettype none
interface icq_req_if;
   import icq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CHUNK_NUM_W-1:0] chunk_number;
   logic [CELL_NUM_W-1:0]  cell_number;
   logic [WORD_W-1:0]      cell_word;
   logic                   layer_kind;
   logic                   new_mesh;

   modport source (
      output valid, chunk_number, cell_number, cell_word, layer_kind, new_mesh,
      input  ready
   );
   modport sink (
      input  valid, chunk_number, cell_number, cell_word, layer_kind, new_mesh,
      output ready
   );
endinterface
`default_nettype wire

// ===== src/icq_rsp_if.sv =====
`default_nettype none
interface icq_rsp_if;
   import icq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SCREEN_W-1:0] screen_x;
   logic [SCREEN_W-1:0]        screen_y;
   logic signed [DEPTH_W-1:0]  depth_tenths;
   logic [TEX_U_W-1:0]         tex_u;
   logic [TEX_V_W-1:0]         tex_v;
   logic [VNUM_W-1:0]          vertex_number;
   logic                       last_vertex;

   modport source (
      output valid, screen_x, screen_y, depth_tenths, tex_u, tex_v, vertex_number,
             last_vertex,
      input  ready
   );
   modport sink (
      input  valid, screen_x, screen_y, depth_tenths, tex_u, tex_v, vertex_number,
             last_vertex,
      output ready
   );
endinterface
`default_nettype wire

// ===== src/isometric_cell_quad_emitter_core.sv =====
// Isometric cell quad emitter. Each accepted cell item is checked against the empty code
// and the hidden mask of the current view direction at the input; a visible cell is
// held in one input register and leaves as four vertex items, one per cycle while the
// output accepts them, through a single output register; its first vertex is shown once
// it has passed the input register and then the output register. An empty or hidden
// cell leaves the input register without waiting on the output and produces nothing.
// Vertex numbers are assigned when the cell is accepted; new_mesh restarts them at zero
// even for a skipped cell. The configuration registers sit on an APB-style port at byte
// addresses 0 to 20 and are to be written only while the block holds no item.
`default_nettype none
module isometric_cell_quad_emitter_core (
   input  wire                          clock,
   input  wire                          reset,
   icq_req_if.sink                      req_chan,
   icq_rsp_if.source                    rsp_chan,
   input  wire                          csr_psel,
   input  wire                          csr_penable,
   input  wire                          csr_pwrite,
   input  wire  [icq_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire  [icq_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [icq_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import icq_pkg::*;

   // configuration
   logic [1:0]        view_ff;
   logic [WORD_W-1:0] empty_ff;
   logic [WORD_W-1:0] mask_ff [4];
   logic [REG_IDX_W-1:0] reg_idx;
   logic              csr_write;

   // input stage
   logic              in_v_ff, in_v_in;
   cell_type          in_item_ff, in_item_in;
   logic [1:0]        corner_ff, corner_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // output stage
   logic                       out_v_ff, out_v_in;
   logic signed [SCREEN_W-1:0] sx_ff, sx_in;
   logic [SCREEN_W-1:0]        sy_ff, sy_in;
   logic signed [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [TEX_U_W-1:0]         tu_ff, tu_in;
   logic [TEX_V_W-1:0]         tv_ff, tv_in;
   logic [VNUM_W-1:0]          vnum_ff, vnum_in;
   logic                       last_ff, last_in;

   logic              req_fire, visible, out_free, emit, in_done;
   logic [COUNT_W-1:0] base_count;
   geo_type           pos_x, pos_y, pos_z, rot_a, rot_b, px, py, depth;
   logic              right, top;

   // register port
   assign reg_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_idx)
         REG_VIEW:   csr_prdata = DATA_W'(view_ff);
         REG_EMPTY:  csr_prdata = empty_ff;
         REG_MASK_N: csr_prdata = mask_ff[DIR_NORTH];
         REG_MASK_W: csr_prdata = mask_ff[DIR_WEST];
         REG_MASK_S: csr_prdata = mask_ff[DIR_SOUTH];
         REG_MASK_E: csr_prdata = mask_ff[DIR_EAST];
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff  <= DIR_NORTH;
         empty_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (reg_idx)
            REG_VIEW:   view_ff            <= csr_pwdata[1:0];
            REG_EMPTY:  empty_ff           <= csr_pwdata;
            REG_MASK_N: mask_ff[DIR_NORTH] <= csr_pwdata;
            REG_MASK_W: mask_ff[DIR_WEST]  <= csr_pwdata;
            REG_MASK_S: mask_ff[DIR_SOUTH] <= csr_pwdata;
            REG_MASK_E: mask_ff[DIR_EAST]  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // handshake and vertex numbering
   assign out_free = ~out_v_ff | rsp_chan.ready;
   assign emit     = in_v_ff & in_item_ff.visible & out_free;
   assign in_done  = in_v_ff & (~in_item_ff.visible | (emit & (corner_ff == LAST_CORNER)));
   assign req_chan.ready = ~in_v_ff | in_done;
   assign req_fire = req_chan.valid & req_chan.ready;

   assign visible = (req_chan.cell_word != empty_ff)
                  && ((req_chan.cell_word & mask_ff[view_ff]) == '0);
   assign base_count = req_chan.new_mesh ? '0 : count_ff;

   always_comb begin
      count_in   = count_ff;
      in_v_in    = in_v_ff & ~in_done;
      in_item_in = in_item_ff;
      corner_in  = corner_ff;
      if (emit) begin
         corner_in = corner_ff + 2'd1;
      end
      if (req_fire) begin
         in_v_in                 = 1'b1;
         in_item_in.chunk_number = req_chan.chunk_number;
         in_item_in.cell_number  = req_chan.cell_number;
         in_item_in.layer_kind   = req_chan.layer_kind;
         in_item_in.visible      = visible;
         in_item_in.base_count   = base_count;
         corner_in               = 2'd0;
         count_in = visible ? COUNT_W'(base_count + COUNT_W'(4)) : base_count;
      end
   end

   // geometry of the held cell
   always_comb begin
      pos_x = geo_type'(in_item_ff.cell_number % CHUNK_LENGTH
            + (in_item_ff.chunk_number % REGION_LENGTH) * CHUNK_LENGTH);
      pos_y = geo_type'((in_item_ff.cell_number % CELL_AREA) / CHUNK_LENGTH
            + ((in_item_ff.chunk_number % CHUNK_AREA) / REGION_LENGTH) * CHUNK_WIDTH);
      pos_z = geo_type'(in_item_ff.cell_number / CELL_AREA
            + (in_item_ff.chunk_number / CHUNK_AREA) * CHUNK_HEIGHT);
      case (view_ff)
         DIR_NORTH: begin
            rot_a = pos_x;
            rot_b = pos_y;
         end
         DIR_WEST: begin
            rot_a = geo_type'(WORLD_WID - 1) - pos_y;
            rot_b = pos_x;
         end
         DIR_SOUTH: begin
            rot_a = geo_type'(WORLD_LEN - 1) - pos_x;
            rot_b = geo_type'(WORLD_WID - 1) - pos_y;
         end
         default: begin
            rot_a = pos_y;
            rot_b = geo_type'(WORLD_LEN - 1) - pos_x;
         end
      endcase
      px    = geo_type'(HALF_TILE_X * (rot_b - rot_a));
      py    = geo_type'(ISO_STEP_Y * (rot_a + rot_b) + LEVEL_STEP_Y * pos_z);
      depth = geo_type'(DEPTH_SCALE * (2 * pos_z - (rot_a + rot_b))
            + (in_item_ff.layer_kind ? 1 : 0));
   end

   // one vertex per cycle while the output is free
   assign right = corner_ff[1];
   assign top   = ~corner_ff[0];

   always_comb begin
      out_v_in = out_v_ff & ~rsp_chan.ready;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      depth_in = depth_ff;
      tu_in    = tu_ff;
      tv_in    = tv_ff;
      vnum_in  = vnum_ff;
      last_in  = last_ff;
      if (emit) begin
         out_v_in = 1'b1;
         sx_in    = SCREEN_W'(px + geo_type'(right ? HALF_TILE_X : -HALF_TILE_X));
         sy_in    = SCREEN_W'(py + geo_type'(top ? QUAD_H : 0));
         depth_in = DEPTH_W'(depth);
         tu_in    = right ? TEX_U_W'(TEX_U_RIGHT) : '0;
         if (in_item_ff.layer_kind) begin
            tv_in = top ? TEX_V_W'(TEX_V_MID) : TEX_V_W'(TEX_V_WALL_BOT);
         end else begin
            tv_in = top ? TEX_V_W'(TEX_V_FLOOR_TOP) : TEX_V_W'(TEX_V_MID);
         end
         vnum_in  = VNUM_W'(in_item_ff.base_count + COUNT_W'(corner_ff));
         last_in  = (corner_ff == LAST_CORNER);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         corner_ff <= 2'd0;
         count_ff  <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         in_v_ff   <= in_v_in;
         corner_ff <= corner_in;
         count_ff  <= count_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      depth_ff   <= depth_in;
      tu_ff      <= tu_in;
      tv_ff      <= tv_in;
      vnum_ff    <= vnum_in;
      last_ff    <= last_in;
   end

   assign rsp_chan.valid         = out_v_ff;
   assign rsp_chan.screen_x      = sx_ff;
   assign rsp_chan.screen_y      = sy_ff;
   assign rsp_chan.depth_tenths  = depth_ff;
   assign rsp_chan.tex_u         = tu_ff;
   assign rsp_chan.tex_v         = tv_ff;
   assign rsp_chan.vertex_number = vnum_ff;
   assign rsp_chan.last_vertex   = last_ff;

   // checks
   a_corner_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      corner_ff != 2'd0 |-> in_v_ff && in_item_ff.visible)
      else $error("corner count advanced without a visible cell");

   a_vnum_consecutive: assert property (@(posedge clock) disable iff (reset)
      emit && corner_ff != 2'd0 |=> vnum_ff == VNUM_W'($past(vnum_ff) + VNUM_W'(1)))
      else $error("vertex numbers within a quad not consecutive");

   a_last_matches_corner: assert property (@(posedge clock) disable iff (reset)
      emit |=> last_ff == ($past(corner_ff) == LAST_CORNER))
      else $error("last vertex flag out of step");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_v_ff |-> req_chan.ready)
      else $error("input refused while the input stage is empty");

endmodule
`default_nettype wire

// ===== bench/tb_isometric_cell_quad_emitter_core.sv =====
`timescale 1ns / 100ps
module tb_isometric_cell_quad_emitter_core;
   import icq_pkg::*;

   localparam int GRID_CHUNKS_X = 8;
   localparam int GRID_CHUNKS_Y = 8;
   localparam int CHUNK_CELLS_X = 16;
   localparam int CHUNK_CELLS_Y = 16;
   localparam int CHUNK_CELLS_Z = 8;
   localparam int WORLD_X = GRID_CHUNKS_X * CHUNK_CELLS_X;
   localparam int WORLD_Y = GRID_CHUNKS_Y * CHUNK_CELLS_Y;
   localparam int HALF_W = 27;
   localparam int STEP_Y = 18;
   localparam int LEVEL_Y = 30;
   localparam int QUAD_RISE = 68;
   localparam int TEX_RIGHT = 54;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 50;

   typedef enum logic [1:0] {ROW_CELL, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {HAND_NONE, HAND_CORNER, HAND_SKIP} hand_kind_type;

   typedef struct packed {
      logic [CHUNK_NUM_W-1:0] chunk_number;
      logic [CELL_NUM_W-1:0]  cell_number;
      logic [WORD_W-1:0]      cell_word;
      logic                   layer_kind;
      logic                   new_mesh;
   } cell_item_type;

   typedef struct packed {
      logic signed [SCREEN_W-1:0] screen_x;
      logic [SCREEN_W-1:0]        screen_y;
      logic signed [DEPTH_W-1:0]  depth_tenths;
      logic [TEX_U_W-1:0]         tex_u;
      logic [TEX_V_W-1:0]         tex_v;
      logic [VNUM_W-1:0]          vertex_number;
      logic                       last_vertex;
   } vertex_type;

   typedef struct packed {
      row_kind_type           kind;
      hand_kind_type          hand;
      logic [REG_IDX_W-1:0]   reg_index;
      logic [DATA_W-1:0]      reg_value;
      cell_item_type          item;
      int                     hand_x;
      int                     hand_y;
      int                     hand_depth;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   icq_req_if req_bus ();
   icq_rsp_if rsp_bus ();

   isometric_cell_quad_emitter_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and vertex counter
   logic [1:0]         view_q = DIR_NORTH;
   logic [WORD_W-1:0]  empty_code_q = '0;
   logic [WORD_W-1:0]  hidden_mask_q [4] = '{default: '0};
   logic [COUNT_W-1:0] vertex_tally = '0;

   vertex_type pending_vertices [$];
   hand_kind_type offer_hand = HAND_NONE;
   int offer_hand_x = 0;
   int offer_hand_y = 0;
   int offer_hand_depth = 0;

   int fail_count = 0;
   int cells_accepted = 0;
   int cells_skipped = 0;
   int vertices_seen = 0;
   int csr_writes = 0;

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic logic [WORD_W-1:0] pick_mask(input bit active);
      case ($urandom_range(0, active ? 2 : 3))
         0: return '0;
         1: return 32'h1 << $urandom_range(0, 31);
         2: return $urandom & $urandom & $urandom;
         default: return '1;
      endcase
   endfunction

   function automatic directed_row_type cell_row(input int chunk_no, input int cell_no,
         input logic [WORD_W-1:0] word, input bit layer, input bit restart,
         input hand_kind_type hand, input int hx = 0, input int hy = 0, input int hd = 0);
      directed_row_type row;
      row = '0;
      row.kind = ROW_CELL;
      row.hand = hand;
      row.item.chunk_number = chunk_no[CHUNK_NUM_W-1:0];
      row.item.cell_number = cell_no[CELL_NUM_W-1:0];
      row.item.cell_word = word;
      row.item.layer_kind = layer;
      row.item.new_mesh = restart;
      row.hand_x = hx;
      row.hand_y = hy;
      row.hand_depth = hd;
      return row;
   endfunction

   function automatic directed_row_type csr_row(input logic [REG_IDX_W-1:0] idx,
         input logic [DATA_W-1:0] value);
      directed_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.hand = HAND_NONE;
      row.reg_index = idx;
      row.reg_value = value;
      return row;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // expected vertices of one accepted cell item
   task automatic project_cell(input cell_item_type ci, input hand_kind_type hand,
         input int hand_x, input int hand_y, input int hand_depth);
      int chunk_z, chunk_rest, chunk_y, chunk_x;
      int cell_z, cell_rest, cell_y, cell_x;
      int wx, wy, wz, a, b, px, py, depth, v_top, v_bot, t;
      vertex_type v;
      cells_accepted++;
      if (ci.new_mesh) vertex_tally = '0;
      if (ci.cell_word == empty_code_q || (ci.cell_word & hidden_mask_q[view_q]) != '0 ||
            hand == HAND_SKIP) begin
         cells_skipped++;
         return;
      end
      chunk_z = int'(ci.chunk_number) / (GRID_CHUNKS_X * GRID_CHUNKS_Y);
      chunk_rest = int'(ci.chunk_number) - chunk_z * GRID_CHUNKS_X * GRID_CHUNKS_Y;
      chunk_y = chunk_rest / GRID_CHUNKS_X;
      chunk_x = chunk_rest % GRID_CHUNKS_X;
      cell_z = int'(ci.cell_number) / (CHUNK_CELLS_X * CHUNK_CELLS_Y);
      cell_rest = int'(ci.cell_number) - cell_z * CHUNK_CELLS_X * CHUNK_CELLS_Y;
      cell_y = cell_rest / CHUNK_CELLS_X;
      cell_x = cell_rest % CHUNK_CELLS_X;
      wx = cell_x + chunk_x * CHUNK_CELLS_X;
      wy = cell_y + chunk_y * CHUNK_CELLS_Y;
      wz = cell_z + chunk_z * CHUNK_CELLS_Z;
      case (view_q)
         DIR_NORTH: begin
            a = wx;
            b = wy;
         end
         DIR_WEST: begin
            a = WORLD_Y - 1 - wy;
            b = wx;
         end
         DIR_SOUTH: begin
            a = WORLD_X - 1 - wx;
            b = WORLD_Y - 1 - wy;
         end
         default: begin
            a = wy;
            b = WORLD_X - 1 - wx;
         end
      endcase
      px = HALF_W * (b - a);
      py = STEP_Y * (a + b) + LEVEL_Y * wz;
      depth = 10 * (2 * wz - (a + b)) + int'(ci.layer_kind);
      v_top = ci.layer_kind ? 444 : 376;
      v_bot = ci.layer_kind ? 512 : 444;
      for (int k = 0; k < 4; k++) begin
         t = px + ((k >= 2) ? HALF_W : -HALF_W);
         v.screen_x = t[SCREEN_W-1:0];
         t = py + ((k % 2 == 0) ? QUAD_RISE : 0);
         v.screen_y = t[SCREEN_W-1:0];
         v.depth_tenths = depth[DEPTH_W-1:0];
         if (k == 0 && hand == HAND_CORNER) begin
            v.screen_x = hand_x[SCREEN_W-1:0];
            v.screen_y = hand_y[SCREEN_W-1:0];
            v.depth_tenths = hand_depth[DEPTH_W-1:0];
         end
         t = (k >= 2) ? TEX_RIGHT : 0;
         v.tex_u = t[TEX_U_W-1:0];
         t = (k % 2 == 0) ? v_top : v_bot;
         v.tex_v = t[TEX_V_W-1:0];
         v.vertex_number = vertex_tally[VNUM_W-1:0];
         v.last_vertex = (k == 3);
         pending_vertices = {pending_vertices, v};
         vertex_tally = vertex_tally + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      vertex_type want;
      cell_item_type taken;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken.chunk_number = req_bus.chunk_number;
            taken.cell_number = req_bus.cell_number;
            taken.cell_word = req_bus.cell_word;
            taken.layer_kind = req_bus.layer_kind;
            taken.new_mesh = req_bus.new_mesh;
            project_cell(taken, offer_hand, offer_hand_x, offer_hand_y, offer_hand_depth);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            vertices_seen++;
            if (pending_vertices.size() == 0) begin
               $error("vertex item with none expected: x %0d y %0d number %0d",
                      rsp_bus.screen_x, rsp_bus.screen_y, rsp_bus.vertex_number);
               fail_count++;
            end else begin
               want = pending_vertices.pop_front();
               check_field("screen_x", $signed(want.screen_x), $signed(rsp_bus.screen_x));
               check_field("screen_y", want.screen_y, rsp_bus.screen_y);
               check_field("depth_tenths", $signed(want.depth_tenths),
                           $signed(rsp_bus.depth_tenths));
               check_field("tex_u", want.tex_u, rsp_bus.tex_u);
               check_field("tex_v", want.tex_v, rsp_bus.tex_v);
               check_field("vertex_number", want.vertex_number, rsp_bus.vertex_number);
               check_field("last_vertex", want.last_vertex, rsp_bus.last_vertex);
            end
         end
      end
   end

   // result side: random stalls, steady runs and one long hold-off
   initial begin
      int stall_left;
      int steady_left;
      int gap;
      bit long_hold_done;
      stall_left = 0;
      steady_left = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (steady_left != 0) begin
            rsp_bus.ready = 1'b1;
            steady_left--;
         end else if (!long_hold_done && vertices_seen >= 150) begin
            long_hold_done = 1'b1;
            rsp_bus.ready = 1'b0;
            stall_left = 149;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_bus.ready = 1'b1;
            steady_left = 40;
         end else begin
            gap = pick_gap(1'b0);
            rsp_bus.ready = (gap == 0);
            if (gap != 0) stall_left = gap - 1;
         end
      end
   end

   task automatic offer_cell(input cell_item_type ci, input bit calm,
         input hand_kind_type hand, input int hx, input int hy, input int hd);
      int gap;
      gap = pick_gap(calm);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.chunk_number = ci.chunk_number;
      req_bus.cell_number = ci.cell_number;
      req_bus.cell_word = ci.cell_word;
      req_bus.layer_kind = ci.layer_kind;
      req_bus.new_mesh = ci.new_mesh;
      offer_hand = hand;
      offer_hand_x = hx;
      offer_hand_y = hy;
      offer_hand_depth = hd;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_bus.valid = 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      csr_pwrite = 1'b1;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_writes++;
      case (idx)
         REG_VIEW: view_q = value[1:0];
         REG_EMPTY: empty_code_q = value;
         REG_MASK_N: hidden_mask_q[DIR_NORTH] = value;
         REG_MASK_W: hidden_mask_q[DIR_WEST] = value;
         REG_MASK_S: hidden_mask_q[DIR_SOUTH] = value;
         REG_MASK_E: hidden_mask_q[DIR_EAST] = value;
         default: ;
      endcase
   endtask

   initial begin
      directed_row_type directed_rows [$];
      directed_row_type row;
      cell_item_type ci;
      logic [1:0] view_pick;
      logic [WORD_W-1:0] empty_pick;
      int pick;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.chunk_number = '0;
      req_bus.cell_number = '0;
      req_bus.cell_word = '0;
      req_bus.layer_kind = 1'b0;
      req_bus.new_mesh = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      // reset values: north view, empty code zero, no masks
      directed_rows = {directed_rows, cell_row(0, 0, 32'h1, 0, 0, HAND_CORNER, -27, 68, 0)};
      directed_rows = {directed_rows, cell_row(0, 0, 32'h0, 0, 0, HAND_SKIP)};
      directed_rows = {directed_rows, cell_row(255, 2047, 32'hFFFF_FFFF, 1, 1, HAND_CORNER,
                                               -27, 5570, -1919)};
      directed_rows = {directed_rows, cell_row(63, 255, 32'h2, 0, 0, HAND_CORNER,
                                               -27, 4640, -2540)};
      directed_rows = {directed_rows, cell_row(7, 15, 32'h8000_0000, 1, 0, HAND_CORNER,
                                               -3456, 2354, -1269)};
      directed_rows = {directed_rows, cell_row(56, 240, 32'h5555_5555, 0, 0, HAND_NONE)};
      directed_rows = {directed_rows, csr_row(REG_EMPTY, 32'hDEAD_BEEF)};
      directed_rows = {directed_rows, cell_row(1, 2, 32'hDEAD_BEEF, 0, 0, HAND_SKIP)};
      directed_rows = {directed_rows, cell_row(3, 100, 32'h0, 1, 1, HAND_NONE)};
      directed_rows = {directed_rows, csr_row(REG_MASK_N, 32'h8000_0001)};
      // hidden cell still restarts the numbering
      directed_rows = {directed_rows, cell_row(9, 9, 32'h8000_0000, 0, 1, HAND_SKIP)};
      directed_rows = {directed_rows, cell_row(10, 10, 32'h1, 1, 0, HAND_SKIP)};
      directed_rows = {directed_rows, cell_row(64, 256, 32'h7FFF_FFFE, 1, 0, HAND_NONE)};
      directed_rows = {directed_rows, csr_row(REG_MASK_W, 32'h0000_00F0)};
      directed_rows = {directed_rows, csr_row(REG_MASK_S, 32'h0F00_0000)};
      directed_rows = {directed_rows, csr_row(REG_MASK_E, 32'hFFFF_FFFF)};
      directed_rows = {directed_rows, csr_row(REG_VIEW, {30'd0, DIR_WEST})};
      directed_rows = {directed_rows, cell_row(0, 0, 32'h10, 0, 0, HAND_SKIP)};
      directed_rows = {directed_rows, cell_row(63, 255, 32'h1, 0, 0, HAND_NONE)};
      directed_rows = {directed_rows, cell_row(7, 15, 32'h8000_0000, 1, 0, HAND_NONE)};
      directed_rows = {directed_rows, csr_row(REG_VIEW, {30'd0, DIR_SOUTH})};
      directed_rows = {directed_rows, cell_row(0, 0, 32'h0100_0000, 0, 0, HAND_SKIP)};
      directed_rows = {directed_rows, cell_row(0, 0, 32'h5, 0, 0, HAND_NONE)};
      directed_rows = {directed_rows, cell_row(255, 2047, 32'hF0FF_FFFF, 1, 0, HAND_NONE)};
      directed_rows = {directed_rows, csr_row(REG_VIEW, {30'd0, DIR_EAST})};
      directed_rows = {directed_rows, cell_row(200, 1500, 32'h1, 0, 0, HAND_SKIP)};
      directed_rows = {directed_rows, cell_row(255, 2047, 32'h0, 1, 1, HAND_NONE)};
      directed_rows = {directed_rows, cell_row(0, 0, 32'h0, 0, 0, HAND_NONE)};

      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_quiet();
            write_csr(row.reg_index, row.reg_value);
         end else begin
            offer_cell(row.item, 1'b0, row.hand, row.hand_x, row.hand_y, row.hand_depth);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_quiet();
         view_pick = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
         if (phase == 1) empty_pick = '1;
         else if (phase == 3) empty_pick = '0;
         else empty_pick = $urandom;
         write_csr(REG_VIEW, {30'd0, view_pick});
         write_csr(REG_EMPTY, empty_pick);
         write_csr(REG_MASK_N, pick_mask(view_pick == DIR_NORTH));
         write_csr(REG_MASK_W, pick_mask(view_pick == DIR_WEST));
         write_csr(REG_MASK_S, pick_mask(view_pick == DIR_SOUTH));
         write_csr(REG_MASK_E, pick_mask(view_pick == DIR_EAST));
         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            ci.chunk_number = CHUNK_NUM_W'($urandom);
            ci.cell_number = CELL_NUM_W'($urandom);
            if (pick < 8) ci.cell_word = empty_code_q;
            else if (pick < 24) ci.cell_word = $urandom;
            else ci.cell_word = $urandom & ~hidden_mask_q[view_q];
            ci.layer_kind = 1'($urandom);
            ci.new_mesh = ($urandom_range(0, 19) == 0);
            offer_cell(ci, phase == 2, HAND_NONE, 0, 0, 0);
         end
      end

      wait_quiet();
      $display("run covered %0d cell items over all four view directions, %0d empty or hidden",
               cells_accepted, cells_skipped);
      $display("%0d vertex items compared, %0d register writes", vertices_seen, csr_writes);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout with %0d vertex items outstanding", pending_vertices.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
